FILE: rtl/ripp_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the
// rotated image page placement unit. No dependencies.
package ripp_pkg;

    // CORDIC rotations, one pipeline stage each (8 to 24).
    localparam int CORDIC_STEPS = 16;
    // Quotient bits of the shrink-factor dividers, one stage each.
    localparam int DIV_BITS = 24;

    // Angle reduction: bias keeps the angle positive, then floor(u / 36000)
    // by reciprocal multiply (exact for all biased inputs).
    localparam logic [24:0] ANGLE_BIAS  = 25'd8424000;
    localparam logic [24:0] RECIP_36000 = 25'd30541990;
    localparam logic [24:0] FULL_TURN   = 25'd36000;
    localparam logic [15:0] DEG_90      = 16'd9000;
    localparam logic [15:0] DEG_180     = 16'd18000;
    localparam logic [15:0] DEG_270     = 16'd27000;
    localparam logic [15:0] DEG_360     = 16'd36000;

    // Centidegrees to Q16 degrees: floor((th * 65536 + 50) / 100).
    localparam logic [30:0] RECIP_100   = 31'd1374389535;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    // Unity shrink factor, Q24.
    localparam logic [24:0] F_ONE = 25'h1000000;

    // Points conversion: floor(v / 127) on a biased value below 2^32.
    localparam logic [33:0] RECIP_127 = 34'd8657571873;
    localparam logic signed [65:0] TERM_BIAS = 66'sd9151314715547271168;
    localparam logic signed [51:0] LEN_BIAS  = 52'sd139637980889088;
    localparam logic signed [26:0] OUT_BIAS  = 27'sd16777216;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic [19:0] w;
        logic [19:0] h;
        logic [19:0] pw;
        logic [19:0] ph;
    } geo_t;

    // Projected lengths lxx, lyx, lxy, lyy (Q24 mm) and trig magnitudes (Q16).
    typedef struct packed {
        logic [3:0][36:0] len;
        logic [16:0]      c16;
        logic [16:0]      s16;
    } proj_t;

    function automatic logic [23:0] atan_q16(input int unsigned idx);
        logic [23:0] v;
        case (idx)
            0:       v = 24'd2949120;
            1:       v = 24'd1740967;
            2:       v = 24'd919879;
            3:       v = 24'd466945;
            4:       v = 24'd234379;
            5:       v = 24'd117304;
            6:       v = 24'd58666;
            7:       v = 24'd29335;
            8:       v = 24'd14668;
            9:       v = 24'd7334;
            10:      v = 24'd3667;
            11:      v = 24'd1833;
            12:      v = 24'd917;
            13:      v = 24'd458;
            14:      v = 24'd229;
            15:      v = 24'd115;
            16:      v = 24'd57;
            17:      v = 24'd29;
            18:      v = 24'd14;
            19:      v = 24'd7;
            20:      v = 24'd4;
            21:      v = 24'd2;
            22:      v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] r;
        if (v > 27'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -27'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

FILE: rtl/rotated_image_page_placement_unit.sv
// Rotated image page placement: top level, whole datapath.
// Depends on ripp_pkg (constants, types, arctangent table).
//
// Takes one placement request per cycle, with no gaps unless the result side
// stalls, and returns the six affine terms (Q15.8 points) after the 16 CORDIC
// rotation stages and the two 24-stage restoring dividers that form the
// shrink factor, run side by side. The whole pipeline advances whenever the
// output register is empty or being taken, so a stall on the result side
// holds every stage and src_stall follows it. fit_to_page is read by items in
// flight, so write it only when idle.
module rotated_image_page_placement_unit
    import ripp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [19:0] image_width_mm,
    input  logic [19:0] image_height_mm,
    input  logic [19:0] page_width_mm,
    input  logic [19:0] page_height_mm,
    input  logic [23:0] angle_centidegrees,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [23:0] scaled_cos_width,
    output logic [23:0] scaled_sin_width,
    output logic [23:0] neg_sin_height,
    output logic [23:0] scaled_cos_height,
    output logic [23:0] offset_x_points,
    output logic [23:0] offset_y_points
);

    logic adv;
    logic fit_to_page_reg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fit_to_page_reg <= 1'b0;
        else if (cfg_wr_en)
            fit_to_page_reg <= cfg_wr_data;
    end

    // ---------------------------------------------------------------
    // Stage 1: capture, bias the angle positive
    // ---------------------------------------------------------------
    logic        v1_reg;
    geo_t        g1_reg;
    logic [24:0] u1_reg;
    logic signed [25:0] a_biased;

    assign a_biased = $signed({{2{angle_centidegrees[23]}}, angle_centidegrees})
                      + $signed({1'b0, ANGLE_BIAS});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg <= '{w: image_width_mm, h: image_height_mm,
                        pw: page_width_mm, ph: page_height_mm};
            u1_reg <= a_biased[24:0];
        end
    end

    // Stage 2: turn count by reciprocal multiply
    logic        v2_reg;
    geo_t        g2_reg;
    logic [24:0] u2_reg;
    logic [8:0]  turns2_reg;
    logic [49:0] turn_prod;

    assign turn_prod = 50'(u1_reg) * 50'(RECIP_36000);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g2_reg     <= g1_reg;
            u2_reg     <= u1_reg;
            turns2_reg <= turn_prod[48:40];
        end
    end

    // Stage 3: remainder, fold into the first quadrant
    logic        v3_reg;
    geo_t        g3_reg;
    logic [13:0] th3_reg;
    quad_t       quad3_reg;
    logic [24:0] rem_full;
    logic [15:0] r_next;
    logic [15:0] th_next;
    quad_t       quad_next;

    always_comb
    begin
        rem_full = u2_reg - 25'(turns2_reg) * FULL_TURN;
        r_next   = rem_full[15:0];
        if (r_next <= DEG_90)
        begin
            th_next   = r_next;
            quad_next = QUAD_0;
        end
        else if (r_next <= DEG_180)
        begin
            th_next   = DEG_180 - r_next;
            quad_next = QUAD_1;
        end
        else if (r_next <= DEG_270)
        begin
            th_next   = r_next - DEG_180;
            quad_next = QUAD_2;
        end
        else
        begin
            th_next   = DEG_360 - r_next;
            quad_next = QUAD_3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g3_reg    <= g2_reg;
            th3_reg   <= th_next[13:0];
            quad3_reg <= quad_next;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC: entry stage converts to Q16 degrees, then one rotation a stage
    // ---------------------------------------------------------------
    logic               cv_reg   [0:CORDIC_STEPS];
    geo_t               cg_reg   [0:CORDIC_STEPS];
    quad_t              cq_reg   [0:CORDIC_STEPS];
    logic signed [31:0] cx_reg   [0:CORDIC_STEPS];
    logic signed [31:0] cy_reg   [0:CORDIC_STEPS];
    logic signed [23:0] cz_reg   [0:CORDIC_STEPS];
    logic [29:0]        deg_num;
    logic [60:0]        deg_prod;

    assign deg_num  = {th3_reg, 16'd0} + 30'd50;
    assign deg_prod = 61'(deg_num) * 61'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cg_reg[0] <= g3_reg;
            cq_reg[0] <= quad3_reg;
            cx_reg[0] <= CORDIC_GAIN;
            cy_reg[0] <= '0;
            cz_reg[0] <= $signed({1'b0, deg_prod[59:37]});
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cg_reg[i+1] <= cg_reg[i];
                cq_reg[i+1] <= cq_reg[i];
                if (!cz_reg[i][23])
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - $signed(atan_q16(i));
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + $signed(atan_q16(i));
                end
            end
        end
    end

    // Clamp to [0, 1.0] Q30
    logic        v5_reg;
    geo_t        g5_reg;
    quad_t       q5_reg;
    logic [30:0] x5_reg;
    logic [30:0] y5_reg;
    logic [30:0] x_clamp;
    logic [30:0] y_clamp;

    function automatic logic [30:0] clamp_q30(input logic signed [31:0] v);
        logic [30:0] r;
        if (v[31])
            r = '0;
        else if (v > ONE_Q30)
            r = ONE_Q30[30:0];
        else
            r = v[30:0];
        return r;
    endfunction

    assign x_clamp = clamp_q30(cx_reg[CORDIC_STEPS]);
    assign y_clamp = clamp_q30(cy_reg[CORDIC_STEPS]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g5_reg <= cg_reg[CORDIC_STEPS];
            q5_reg <= cq_reg[CORDIC_STEPS];
            x5_reg <= x_clamp;
            y5_reg <= y_clamp;
        end
    end

    // Projections of the rotated box, rounded to Q24
    logic  v6_reg;
    geo_t  g6_reg;
    quad_t q6_reg;
    proj_t p6_reg;
    proj_t p_next;
    logic [30:0] c_round;
    logic [30:0] s_round;

    function automatic logic [36:0] proj_len(input logic [19:0] sz, input logic [30:0] m);
        logic [50:0] p;
        p = 51'(sz) * 51'(m) + 51'd8192;
        return p[50:14];
    endfunction

    always_comb
    begin
        p_next.len[0] = proj_len(g5_reg.w, x5_reg);
        p_next.len[1] = proj_len(g5_reg.h, y5_reg);
        p_next.len[2] = proj_len(g5_reg.w, y5_reg);
        p_next.len[3] = proj_len(g5_reg.h, x5_reg);
        c_round       = x5_reg + 31'd8192;
        s_round       = y5_reg + 31'd8192;
        p_next.c16    = c_round[30:14];
        p_next.s16    = s_round[30:14];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g6_reg <= g5_reg;
            q6_reg <= q5_reg;
            p6_reg <= p_next;
        end
    end

    // ---------------------------------------------------------------
    // Shrink factor: two restoring dividers side by side, page / extent
    // ---------------------------------------------------------------
    logic        dv_reg   [0:DIV_BITS];
    geo_t        dg_reg   [0:DIV_BITS];
    quad_t       dq_reg   [0:DIV_BITS];
    proj_t       dp_reg   [0:DIV_BITS];
    logic        dgx_reg  [0:DIV_BITS];
    logic [37:0] dex_reg  [0:DIV_BITS];
    logic [37:0] dey_reg  [0:DIV_BITS];
    logic [37:0] dr1_reg  [0:DIV_BITS];
    logic [37:0] dr2_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] dq1_reg [0:DIV_BITS];
    logic [DIV_BITS-1:0] dq2_reg [0:DIV_BITS];
    logic [37:0] ext_x;
    logic [37:0] ext_y;

    assign ext_x = {1'b0, p6_reg.len[0]} + {1'b0, p6_reg.len[1]};
    assign ext_y = {1'b0, p6_reg.len[2]} + {1'b0, p6_reg.len[3]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dg_reg[0]  <= g6_reg;
            dq_reg[0]  <= q6_reg;
            dp_reg[0]  <= p6_reg;
            dex_reg[0] <= ext_x;
            dey_reg[0] <= ext_y;
            dgx_reg[0] <= ext_x > {2'b0, g6_reg.pw, 16'd0};
            dr1_reg[0] <= {2'b0, g6_reg.pw, 16'd0};
            dr2_reg[0] <= {2'b0, g6_reg.ph, 16'd0};
            dq1_reg[0] <= '0;
            dq2_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        logic [38:0] t1;
        logic [38:0] t2;
        logic        ge1;
        logic        ge2;
        logic [38:0] d1;
        logic [38:0] d2;

        always_comb
        begin
            t1  = {dr1_reg[k], 1'b0};
            t2  = {dr2_reg[k], 1'b0};
            ge1 = t1 >= {1'b0, dex_reg[k]};
            ge2 = t2 >= {1'b0, dey_reg[k]};
            d1  = ge1 ? t1 - {1'b0, dex_reg[k]} : t1;
            d2  = ge2 ? t2 - {1'b0, dey_reg[k]} : t2;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dg_reg[k+1]  <= dg_reg[k];
                dq_reg[k+1]  <= dq_reg[k];
                dp_reg[k+1]  <= dp_reg[k];
                dex_reg[k+1] <= dex_reg[k];
                dey_reg[k+1] <= dey_reg[k];
                dgx_reg[k+1] <= dgx_reg[k];
                dr1_reg[k+1] <= d1[37:0];
                dr2_reg[k+1] <= d2[37:0];
                dq1_reg[k+1] <= {dq1_reg[k][DIV_BITS-2:0], ge1};
                dq2_reg[k+1] <= {dq2_reg[k][DIV_BITS-2:0], ge2};
            end
        end
    end

    // F1: width-limited factor, then extent_y times it in two halves
    logic        v8_reg;
    geo_t        g8_reg;
    quad_t       q8_reg;
    proj_t       p8_reg;
    logic [24:0] f1_8_reg;
    logic [24:0] fq2_8_reg;
    logic [43:0] pyh8_reg;
    logic [43:0] pyl8_reg;
    logic [24:0] f1_next;
    logic [37:0] ey_div;

    assign ey_div  = dey_reg[DIV_BITS];
    assign f1_next = dgx_reg[DIV_BITS] ? {1'b0, dq1_reg[DIV_BITS]} : F_ONE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g8_reg    <= dg_reg[DIV_BITS];
            q8_reg    <= dq_reg[DIV_BITS];
            p8_reg    <= dp_reg[DIV_BITS];
            f1_8_reg  <= f1_next;
            fq2_8_reg <= {1'b0, dq2_reg[DIV_BITS]};
            pyh8_reg  <= 44'(ey_div[37:19]) * 44'(f1_next);
            pyl8_reg  <= 44'(ey_div[18:0]) * 44'(f1_next);
        end
    end

    // F2: fit_to_page and the height check pick the final factor
    logic        v9_reg;
    geo_t        g9_reg;
    quad_t       q9_reg;
    proj_t       p9_reg;
    logic [24:0] f9_reg;
    logic [62:0] ey_scaled;
    logic [62:0] ph_limit;
    logic [24:0] f_next;

    always_comb
    begin
        ey_scaled = {pyh8_reg, 19'd0} + {19'd0, pyl8_reg};
        ph_limit  = {3'd0, g8_reg.ph, 40'd0};
        if (!fit_to_page_reg)
            f_next = F_ONE;
        else if (ey_scaled > ph_limit)
            f_next = fq2_8_reg;
        else
            f_next = f1_8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g9_reg <= g8_reg;
            q9_reg <= q8_reg;
            p9_reg <= p8_reg;
            f9_reg <= f_next;
        end
    end

    // M1: scale partial products
    logic        v10_reg;
    geo_t        g10_reg;
    quad_t       q10_reg;
    logic [16:0] c10_reg;
    logic [16:0] s10_reg;
    logic [42:0] lh10_reg [0:3];
    logic [43:0] ll10_reg [0:3];
    logic [44:0] wf10_reg;
    logic [44:0] hf10_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g10_reg  <= g9_reg;
            q10_reg  <= q9_reg;
            c10_reg  <= p9_reg.c16;
            s10_reg  <= p9_reg.s16;
            for (int j = 0; j < 4; j++)
            begin
                lh10_reg[j] <= 43'(p9_reg.len[j][36:19]) * 43'(f9_reg);
                ll10_reg[j] <= 44'(p9_reg.len[j][18:0]) * 44'(f9_reg);
            end
            wf10_reg <= 45'(g9_reg.w) * 45'(f9_reg);
            hf10_reg <= 45'(g9_reg.h) * 45'(f9_reg);
        end
    end

    // M2: recombine and drop the Q24 factor fraction
    logic        v11_reg;
    geo_t        g11_reg;
    quad_t       q11_reg;
    logic [16:0] c11_reg;
    logic [16:0] s11_reg;
    logic [36:0] ls11_reg [0:3];
    logic [35:0] wq11_reg;
    logic [35:0] hq11_reg;
    logic [61:0] ls_sum [0:3];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            ls_sum[j] = {lh10_reg[j], 19'd0} + 62'(ll10_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g11_reg <= g10_reg;
            q11_reg <= q10_reg;
            c11_reg <= c10_reg;
            s11_reg <= s10_reg;
            for (int j = 0; j < 4; j++)
                ls11_reg[j] <= ls_sum[j][60:24];
            wq11_reg <= wf10_reg[43:8];
            hq11_reg <= hf10_reg[43:8];
        end
    end

    // M3: centring margins and matrix-term partial products
    logic               v12_reg;
    quad_t              q12_reg;
    logic signed [39:0] mx12_reg;
    logic signed [39:0] my12_reg;
    logic [34:0]        th12_reg [0:3];
    logic [34:0]        tl12_reg [0:3];
    logic [37:0]        ex_s;
    logic [37:0]        ey_s;
    logic [37:0]        add_x;
    logic [37:0]        add_y;
    logic signed [39:0] bx;
    logic signed [39:0] by;
    logic signed [39:0] mx_next;
    logic signed [39:0] my_next;
    logic [35:0]        t_size [0:3];
    logic [16:0]        t_trig [0:3];

    always_comb
    begin
        ex_s = {1'b0, ls11_reg[0]} + {1'b0, ls11_reg[1]};
        ey_s = {1'b0, ls11_reg[2]} + {1'b0, ls11_reg[3]};
        bx   = $signed({4'd0, g11_reg.pw, 16'd0}) - $signed({2'd0, ex_s});
        by   = $signed({4'd0, g11_reg.ph, 16'd0}) - $signed({2'd0, ey_s});
        case (q11_reg)
            QUAD_0:
            begin
                add_x = {1'b0, ls11_reg[1]};
                add_y = '0;
            end
            QUAD_1:
            begin
                add_x = ex_s;
                add_y = {1'b0, ls11_reg[3]};
            end
            QUAD_2:
            begin
                add_x = {1'b0, ls11_reg[0]};
                add_y = ey_s;
            end
            default:
            begin
                add_x = '0;
                add_y = {1'b0, ls11_reg[2]};
            end
        endcase
        mx_next = (bx >>> 1) + $signed({2'd0, add_x});
        my_next = (by >>> 1) + $signed({2'd0, add_y});
        // terms: w*cos, w*sin, -h*sin, h*cos
        t_size[0] = wq11_reg;
        t_size[1] = wq11_reg;
        t_size[2] = hq11_reg;
        t_size[3] = hq11_reg;
        t_trig[0] = c11_reg;
        t_trig[1] = s11_reg;
        t_trig[2] = s11_reg;
        t_trig[3] = c11_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q12_reg  <= q11_reg;
            mx12_reg <= mx_next;
            my12_reg <= my_next;
            for (int j = 0; j < 4; j++)
            begin
                th12_reg[j] <= 35'(t_size[j][35:18]) * 35'(t_trig[j]);
                tl12_reg[j] <= 35'(t_size[j][17:0]) * 35'(t_trig[j]);
            end
        end
    end

    // M4: signed matrix products; margins biased and scaled by 360
    logic               v13_reg;
    logic signed [54:0] ts13_reg [0:3];
    logic [31:0]        ul13_reg [0:1];
    logic [53:0]        t_mag [0:3];
    logic [3:0]         t_neg;
    logic signed [51:0] nx;
    logic signed [51:0] ny;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            t_mag[j] = {1'b0, th12_reg[j], 18'd0} + 54'(tl12_reg[j]);
        // sign of cos is negative in quadrants 1 and 2, of sin in 2 and 3
        t_neg[0] = (q12_reg == QUAD_1) || (q12_reg == QUAD_2);
        t_neg[1] = (q12_reg == QUAD_2) || (q12_reg == QUAD_3);
        t_neg[2] = (q12_reg == QUAD_0) || (q12_reg == QUAD_1);
        t_neg[3] = t_neg[0];
        nx = 52'(mx12_reg) * 52'sd360 + LEN_BIAS;
        ny = 52'(my12_reg) * 52'sd360 + LEN_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
                ts13_reg[j] <= t_neg[j] ? -$signed({1'b0, t_mag[j]})
                                        : $signed({1'b0, t_mag[j]});
            ul13_reg[0] <= nx[47:16];
            ul13_reg[1] <= ny[47:16];
        end
    end

    // M5: matrix terms scaled by 360 and biased
    logic               v14_reg;
    logic [31:0]        u14_reg [0:5];
    logic signed [65:0] tn [0:3];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            tn[j] = 66'(ts13_reg[j]) * 66'sd360 + TERM_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
                u14_reg[j] <= tn[j][63:32];
            u14_reg[4] <= ul13_reg[0];
            u14_reg[5] <= ul13_reg[1];
        end
    end

    // M6: divide by 127 through the reciprocal
    logic        v15_reg;
    logic [25:0] q15_reg [0:5];
    logic [65:0] div_prod [0:5];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
            div_prod[j] = 66'(u14_reg[j]) * 66'(RECIP_127);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 6; j++)
                q15_reg[j] <= div_prod[j][65:40];
        end
    end

    // Output register: remove bias, saturate
    logic        out_valid_reg;
    logic [23:0] out_reg [0:5];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 6; j++)
                out_reg[j] <= sat24($signed({1'b0, q15_reg[j]}) - OUT_BIAS);
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            v15_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= CORDIC_STEPS; i++)
                cv_reg[i] <= 1'b0;
            for (int k = 0; k <= DIV_BITS; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= src_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            cv_reg[0] <= v3_reg;
            for (int i = 0; i < CORDIC_STEPS; i++)
                cv_reg[i+1] <= cv_reg[i];
            v5_reg    <= cv_reg[CORDIC_STEPS];
            v6_reg    <= v5_reg;
            dv_reg[0] <= v6_reg;
            for (int k = 0; k < DIV_BITS; k++)
                dv_reg[k+1] <= dv_reg[k];
            v8_reg        <= dv_reg[DIV_BITS];
            v9_reg        <= v8_reg;
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            v12_reg       <= v11_reg;
            v13_reg       <= v12_reg;
            v14_reg       <= v13_reg;
            v15_reg       <= v14_reg;
            out_valid_reg <= v15_reg;
        end
    end

    // Whole pipe moves unless the finished item is held
    assign adv       = !out_valid_reg || !res_stall;
    assign src_stall = !adv;

    assign res_valid         = out_valid_reg;
    assign scaled_cos_width  = out_reg[0];
    assign scaled_sin_width  = out_reg[1];
    assign neg_sin_height    = out_reg[2];
    assign scaled_cos_height = out_reg[3];
    assign offset_x_points   = out_reg[4];
    assign offset_y_points   = out_reg[5];

endmodule

FILE: tb/sv/tb_rotated_image_page_placement_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotated_image_page_placement_unit.
// Depends on ripp_pkg and the unit's RTL; predicts every placement itself.
module tb_rotated_image_page_placement_unit;
    import ripp_pkg::*;

    // One placement request as driven on the source side.
    typedef struct {
        logic [19:0] w;
        logic [19:0] h;
        logic [19:0] pw;
        logic [19:0] ph;
        logic [23:0] ang;
    } request_t;

    // The six affine terms of one placement.
    typedef struct packed {
        logic [23:0] cw;
        logic [23:0] sw;
        logic [23:0] nsh;
        logic [23:0] ch;
        logic [23:0] ox;
        logic [23:0] oy;
    } placement_t;

    // Directed row: the request plus an optional hand-worked placement.
    typedef struct {
        request_t   req;
        bit         typed;
        placement_t want;
    } directed_row_t;

    localparam bit FIT_OFF = 1'b0;
    localparam bit FIT_ON  = 1'b1;
    // Pipeline depth of the unit, with some margin.
    localparam int DRAIN_CYCLES = 70;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        src_valid;
    logic        src_stall;
    logic [19:0] image_width_mm;
    logic [19:0] image_height_mm;
    logic [19:0] page_width_mm;
    logic [19:0] page_height_mm;
    logic [23:0] angle_centidegrees;
    logic        res_valid;
    logic        res_stall;
    logic [23:0] scaled_cos_width;
    logic [23:0] scaled_sin_width;
    logic [23:0] neg_sin_height;
    logic [23:0] scaled_cos_height;
    logic [23:0] offset_x_points;
    logic [23:0] offset_y_points;

    rotated_image_page_placement_unit uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .src_valid          (src_valid),
        .src_stall          (src_stall),
        .image_width_mm     (image_width_mm),
        .image_height_mm    (image_height_mm),
        .page_width_mm      (page_width_mm),
        .page_height_mm     (page_height_mm),
        .angle_centidegrees (angle_centidegrees),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .scaled_cos_width   (scaled_cos_width),
        .scaled_sin_width   (scaled_sin_width),
        .neg_sin_height     (neg_sin_height),
        .scaled_cos_height  (scaled_cos_height),
        .offset_x_points    (offset_x_points),
        .offset_y_points    (offset_y_points)
    );

    // Shadow of the fit_to_page register, used by the predictor.
    bit         fit_shadow;
    // Placements still owed by the unit, oldest first.
    placement_t owed_placements[$];
    int         mismatch_count;
    int         src_idle_pct;
    int         res_stall_pct;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Arctangent of 2^-i in Q16 degrees (same table as the hardware uses).
    function automatic longint atan_step(input int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                          58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                          229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic longint div_floor(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [23:0] clamp24(input longint v);
        longint c;
        c = v;
        if (c > 64'sd8388607)
            c = 64'sd8388607;
        if (c < -64'sd8388608)
            c = -64'sd8388608;
        return c[23:0];
    endfunction

    // Q(F+16) size times signed Q16 trig, as Q15.8 points.
    function automatic logic [23:0] matrix_term(input longint sz, input longint trig);
        return clamp24(div_floor(sz * trig * 360 + 64'sd127 * (64'sd1 << 31),
                                 64'sd127 * (64'sd1 << 32)));
    endfunction

    // Q(F+16) length as Q15.8 points.
    function automatic logic [23:0] offset_term(input longint len);
        return clamp24(div_floor(len * 360 + 64'sd127 * (64'sd1 << 15),
                                 64'sd127 * (64'sd1 << 16)));
    endfunction

    // Predicts the placement of one request under the given fit setting.
    function automatic placement_t predict_placement(input request_t rq, input bit fit);
        placement_t p;
        longint w, h, pw16, ph16, a, r, th, z, x, y, dx, dy, sc, ss;
        longint lxx, lyx, lxy, lyy, wq, hq, mx, my, c16, s16, ext_x, ext_y, f;
        w    = rq.w;
        h    = rq.h;
        pw16 = longint'(rq.pw) << 16;
        ph16 = longint'(rq.ph) << 16;
        a    = longint'(signed'(rq.ang));
        r    = a % 36000;
        if (r < 0)
            r = r + 36000;
        // Fold into the first quadrant, remembering the signs.
        if (r <= 9000)
        begin
            th = r; sc = 1; ss = 1;
        end
        else if (r <= 18000)
        begin
            th = 18000 - r; sc = -1; ss = 1;
        end
        else if (r <= 27000)
        begin
            th = r - 18000; sc = -1; ss = -1;
        end
        else
        begin
            th = 36000 - r; sc = 1; ss = -1;
        end
        z = (th * 65536 + 50) / 100;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_step(i);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_step(i);
            end
        end
        if (x < 0) x = 0;
        if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
        if (y < 0) y = 0;
        if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
        lxx = (w * x + 8192) >>> 14;
        lyx = (h * y + 8192) >>> 14;
        lxy = (w * y + 8192) >>> 14;
        lyy = (h * x + 8192) >>> 14;
        wq  = w << 16;
        hq  = h << 16;
        if (fit)
        begin
            ext_x = lxx + lyx;
            ext_y = lxy + lyy;
            f = 64'sd1 << 24;
            if (ext_x > pw16)
                f = (pw16 << 24) / ext_x;
            if (ext_y * f > (ph16 << 24))
                f = (ph16 << 24) / ext_y;
            lxx = (lxx * f) >>> 24;
            lyx = (lyx * f) >>> 24;
            lxy = (lxy * f) >>> 24;
            lyy = (lyy * f) >>> 24;
            wq  = (wq * f) >>> 24;
            hq  = (hq * f) >>> 24;
        end
        mx = (pw16 - (lxx + lyx)) >>> 1;
        my = (ph16 - (lxy + lyy)) >>> 1;
        // Origin sits on a different corner per quadrant.
        if (r <= 9000)
            mx = mx + lyx;
        else if (r <= 18000)
        begin
            mx = mx + lxx + lyx;
            my = my + lyy;
        end
        else if (r <= 27000)
        begin
            mx = mx + lxx;
            my = my + lxy + lyy;
        end
        else
            my = my + lxy;
        c16 = sc * ((x + 8192) >>> 14);
        s16 = ss * ((y + 8192) >>> 14);
        p.cw  = matrix_term(wq, c16);
        p.sw  = matrix_term(wq, s16);
        p.nsh = matrix_term(hq, -s16);
        p.ch  = matrix_term(hq, c16);
        p.ox  = offset_term(mx);
        p.oy  = offset_term(my);
        return p;
    endfunction

    // Record the owed placement for every item the unit takes.
    always @(posedge clk)
    begin
        request_t rq;
        if (rst_n && src_valid && !src_stall)
        begin
            rq.w   = image_width_mm;
            rq.h   = image_height_mm;
            rq.pw  = page_width_mm;
            rq.ph  = page_height_mm;
            rq.ang = angle_centidegrees;
            owed_placements.push_back(predict_placement(rq, fit_shadow));
        end
    end

    // Result side: random back-pressure and the field-by-field check.
    always @(posedge clk)
    begin
        placement_t want;
        res_stall <= ($urandom_range(99) < res_stall_pct);
        if (rst_n && res_valid && !res_stall)
        begin
            if (owed_placements.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: placement item with nothing owed", $realtime);
            end
            else
            begin
                want = owed_placements.pop_front();
                if (scaled_cos_width !== want.cw || scaled_sin_width !== want.sw ||
                    neg_sin_height !== want.nsh || scaled_cos_height !== want.ch ||
                    offset_x_points !== want.ox || offset_y_points !== want.oy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: want %h %h %h %h %h %h got %h %h %h %h %h %h",
                                 $realtime, want.cw, want.sw, want.nsh, want.ch,
                                 want.ox, want.oy, scaled_cos_width,
                                 scaled_sin_width, neg_sin_height,
                                 scaled_cos_height, offset_x_points,
                                 offset_y_points);
                end
            end
        end
    end

    // Presents one item, with random idle cycles ahead of it, and returns
    // once it is taken. Valid stays high afterwards until the next call.
    task automatic send_request(input request_t rq);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid          <= 1'b1;
        image_width_mm     <= rq.w;
        image_height_mm    <= rq.h;
        page_width_mm      <= rq.pw;
        page_height_mm     <= rq.ph;
        angle_centidegrees <= rq.ang;
        do
            @(posedge clk);
        while (src_stall);
    endtask

    // Waits for every owed placement, then lets the pipe empty.
    task automatic drain_pipe();
        src_valid <= 1'b0;
        @(posedge clk);
        while (owed_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_fit(input bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        fit_shadow  = v;
    endtask

    function automatic logic [19:0] rand_size();
        int k;
        k = $urandom_range(9);
        if (k < 6)
            return 20'($urandom_range(120000, 256));       // up to ~470 mm
        else if (k < 8)
            return 20'($urandom);
        else if (k == 8)
            return 20'($urandom_range(255));
        return 20'hFFFFF;
    endfunction

    function automatic request_t rand_request();
        request_t rq;
        int k;
        rq.w  = rand_size();
        rq.h  = rand_size();
        rq.pw = rand_size();
        rq.ph = rand_size();
        k = $urandom_range(3);
        if (k == 0)
            rq.ang = 24'($urandom);
        else if (k == 1)
            rq.ang = 24'(9000 * $urandom_range(8) - 36000 + $urandom_range(2) - 1);
        else
            rq.ang = 24'($urandom_range(72000) - 36000);
        return rq;
    endfunction

    function automatic request_t mk(input int w, input int h, input int pw,
                                    input int ph, input int ang);
        request_t rq;
        rq.w   = w[19:0];
        rq.h   = h[19:0];
        rq.pw  = pw[19:0];
        rq.ph  = ph[19:0];
        rq.ang = ang[23:0];
        return rq;
    endfunction

    directed_row_t directed_rows[$];

    initial
    begin
        directed_row_t row;
        placement_t    got;
        int            pct[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{25, 25}};

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        src_valid          = 1'b0;
        res_stall          = 1'b0;
        image_width_mm     = '0;
        image_height_mm    = '0;
        page_width_mm      = '0;
        page_height_mm     = '0;
        angle_centidegrees = '0;
        fit_shadow         = FIT_OFF;
        mismatch_count     = 0;
        src_idle_pct       = 0;
        res_stall_pct      = 0;

        // Directed table. Zero sizes at zero angle: every term and offset 0.
        row.typed = 1'b1;
        row.want  = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0};
        row.req   = mk(0, 0, 0, 0, 0);
        directed_rows.push_back(row);
        row.typed = 1'b0;
        // Quadrant edges, a full turn, negatives and the angle extremes.
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 9000), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 18000), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 27000), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 36000), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 9001), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 26999), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, -4500), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, -36000), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 8388607), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, -8388608), 0, row.want});
        directed_rows.push_back('{mk(53760, 38400, 53760, 76032, 3000), 0, row.want});
        // Size extremes: saturation and shrink against tiny or empty pages.
        directed_rows.push_back('{mk(1048575, 1048575, 1048575, 1048575, 4500), 0, row.want});
        directed_rows.push_back('{mk(1048575, 1048575, 0, 0, 13500), 0, row.want});
        directed_rows.push_back('{mk(1048575, 1, 1, 1048575, 22500), 0, row.want});
        directed_rows.push_back('{mk(1, 1048575, 1048575, 1, 31500), 0, row.want});
        directed_rows.push_back('{mk(0, 0, 1048575, 1048575, 12345), 0, row.want});
        directed_rows.push_back('{mk(0, 700000, 256, 256, 6000), 0, row.want});
        directed_rows.push_back('{mk(699050, 349525, 349525, 699050, 0), 0, row.want});
        directed_rows.push_back('{mk(1048575, 1048575, 1048575, 1048575, 0), 0, row.want});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at both fit settings; typed rows only at reset value.
        for (int fit = FIT_OFF; fit <= FIT_ON; fit++)
        begin
            if (fit != FIT_OFF)
                write_fit(1'b1);
            foreach (directed_rows[i])
            begin
                send_request(directed_rows[i].req);
                if (directed_rows[i].typed && fit == FIT_OFF)
                begin
                    got = predict_placement(directed_rows[i].req, fit_shadow);
                    if (got != directed_rows[i].want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("directed row %0d: predictor disagrees", i);
                    end
                end
            end
            drain_pipe();
        end

        // Random items over the idling phases, fit toggled between them.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_fit(ph[0] ? FIT_OFF : FIT_ON);
            src_idle_pct  = pct[ph / 2][0];
            res_stall_pct = pct[ph / 2][1];
            for (int n = 0; n < 115; n++)
            begin
                // Short bursts with no idling at all.
                if ($urandom_range(19) == 0)
                begin
                    src_idle_pct = 0;
                    res_stall_pct = 0;
                end
                else if ($urandom_range(9) == 0)
                begin
                    src_idle_pct  = pct[ph / 2][0];
                    res_stall_pct = pct[ph / 2][1];
                end
                send_request(rand_request());
            end
            drain_pipe();
        end

        if (mismatch_count == 0)
            $display("rotated_image_page_placement_unit verification clean");
        else
            $display("rotated_image_page_placement_unit verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("rotated_image_page_placement_unit verification failed");
        $finish;
    end

endmodule

FILE: rotated_image_page_placement_unit.f
rtl/ripp_pkg.sv
rtl/rotated_image_page_placement_unit.sv
tb/sv/tb_rotated_image_page_placement_unit.sv
